/* src/srecord_s1_parser_top_defines.svh */
// ---------------------------------------------------------------------------
// S1 record parser assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SRECORD_S1_PARSER_TOP_DEFINES_SVH
`define SRECORD_S1_PARSER_TOP_DEFINES_SVH

// Property that must hold at every clock edge.
`define SRP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/srp_pkg.sv */
// ---------------------------------------------------------------------------
// S1 record parser package
// Result kinds, result record and hex digit decode.
// ---------------------------------------------------------------------------
package srp_pkg;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_OK       = 3'd1,
        KIND_MISMATCH = 3'd2,
        KIND_BADHEX   = 3'd3,
        KIND_SHORT    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [15:0] load_address;
        logic [7:0]  byte_count;
        logic [7:0]  received_checksum;
    } result_t;

    localparam logic [7:0] COUNT_MIN = 8'd3;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b0, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

/* src/srecord_s1_parser_top.sv */
// ---------------------------------------------------------------------------
// S1 record parser
// Decodes one S1-style record, one character per request, into data byte
// and end-of-record status results.
// ---------------------------------------------------------------------------
// Input channel: char_code/record_start with in_valid/in_stall. record_start
// marks the first character of a record; it and the next character are the
// type and are skipped. Count, address, data and checksum hex digits follow.
// Output channel: kind plus fields with out_valid/out_stall. A character
// yields zero or one result: one per data byte, and one status at the end
// (ok, checksum mismatch, bad hex character or count below three).
// Results: a result is written into the queue when its character is accepted.
// Throughput: one character per cycle unless in_stall is high; the parser state
// is registered per accepted character; results go into a two-entry queue.
// Stall: while out_stall holds, results collect in the queue; once it holds
// two results, in_stall rises until the receiver takes one.
// Reset: rst_n clears the parser to idle (waiting for record_start) and
// empties the result queue.
// ---------------------------------------------------------------------------
module srecord_s1_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        record_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic [15:0] load_address,
    output logic [7:0]  byte_count,
    output logic [7:0]  received_checksum
);
    import srp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_COUNT = 3'd2,
        PH_ADDR  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } phase_t;

    phase_t      phase_reg,         phase_next;
    logic [1:0]  skip_left_reg,     skip_left_next;
    logic        odd_nibble_reg,    odd_nibble_next;
    logic [3:0]  high_nibble_reg,   high_nibble_next;
    logic [1:0]  field_nibbles_reg, field_nibbles_next;
    logic [7:0]  count_reg,         count_next;
    logic [15:0] address_reg,       address_next;
    logic [7:0]  running_sum_reg,   running_sum_next;
    logic [7:0]  data_left_reg,     data_left_next;
    logic [7:0]  data_index_reg,    data_index_next;

    logic        accept;
    logic        has_result;
    result_t     result;
    result_t     out_data;
    logic        full;
    logic [4:0]  nib;
    logic [7:0]  byte_val;
    logic [1:0]  skip_dec;
    logic [15:0] addr_shift;
    logic [7:0]  left_dec;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = full;
    assign nib        = hex_nibble(char_code);
    assign byte_val   = {high_nibble_reg, nib[3:0]};
    assign skip_dec   = (skip_left_reg != 2'd0) ? skip_left_reg - 2'd1 : 2'd0;
    assign addr_shift = {address_reg[11:0], nib[3:0]};
    assign left_dec   = data_left_reg - 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        skip_left_next     = skip_left_reg;
        odd_nibble_next    = odd_nibble_reg;
        high_nibble_next   = high_nibble_reg;
        field_nibbles_next = field_nibbles_reg;
        count_next         = count_reg;
        address_next       = address_reg;
        running_sum_next   = running_sum_reg;
        data_left_next     = data_left_reg;
        data_index_next    = data_index_reg;
        has_result         = 1'b0;
        result             = '0;

        if (record_start)
        begin
            phase_next         = PH_SKIP;
            skip_left_next     = 2'd1;
            odd_nibble_next    = 1'b0;
            high_nibble_next   = 4'd0;
            field_nibbles_next = 2'd0;
            count_next         = 8'd0;
            address_next       = 16'd0;
            running_sum_next   = 8'd0;
            data_left_next     = 8'd0;
            data_index_next    = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 2'd0)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM:
                begin
                    if (nib[4])
                    begin
                        phase_next  = PH_IDLE;
                        has_result  = 1'b1;
                        result.kind = KIND_BADHEX;
                    end
                    else if (phase_reg == PH_ADDR)
                    begin
                        address_next = addr_shift;
                        if (field_nibbles_reg != 2'd3)
                        begin
                            field_nibbles_next = field_nibbles_reg + 2'd1;
                        end
                        else
                        begin
                            field_nibbles_next = 2'd0;
                            running_sum_next   = running_sum_reg + addr_shift[15:8]
                                                 + addr_shift[7:0];
                            phase_next = (data_left_reg != 8'd0) ? PH_DATA : PH_CSUM;
                        end
                    end
                    else if (!odd_nibble_reg)
                    begin
                        high_nibble_next = nib[3:0];
                        odd_nibble_next  = 1'b1;
                    end
                    else
                    begin
                        odd_nibble_next = 1'b0;
                        if (phase_reg == PH_COUNT)
                        begin
                            count_next = byte_val;
                            if (byte_val < COUNT_MIN)
                            begin
                                phase_next        = PH_IDLE;
                                has_result        = 1'b1;
                                result.kind       = KIND_SHORT;
                                result.byte_count = byte_val;
                            end
                            else
                            begin
                                running_sum_next   = byte_val;
                                data_left_next     = byte_val - COUNT_MIN;
                                data_index_next    = 8'd0;
                                address_next       = 16'd0;
                                field_nibbles_next = 2'd0;
                                phase_next         = PH_ADDR;
                            end
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            running_sum_next    = running_sum_reg + byte_val;
                            data_index_next     = data_index_reg + 8'd1;
                            data_left_next      = left_dec;
                            if (left_dec == 8'd0)
                            begin
                                phase_next = PH_CSUM;
                            end
                            has_result          = 1'b1;
                            result.kind         = KIND_DATA;
                            result.data_byte    = byte_val;
                            result.byte_index   = data_index_reg;
                            result.load_address = address_reg;
                            result.byte_count   = count_reg;
                        end
                        else
                        begin
                            phase_next  = PH_IDLE;
                            has_result  = 1'b1;
                            result.kind = (byte_val == ~running_sum_reg) ? KIND_OK
                                                                         : KIND_MISMATCH;
                            result.load_address      = address_reg;
                            result.byte_count        = count_reg;
                            result.received_checksum = byte_val;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            skip_left_reg     <= 2'd0;
            odd_nibble_reg    <= 1'b0;
            high_nibble_reg   <= 4'd0;
            field_nibbles_reg <= 2'd0;
            count_reg         <= 8'd0;
            address_reg       <= 16'd0;
            running_sum_reg   <= 8'd0;
            data_left_reg     <= 8'd0;
            data_index_reg    <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            skip_left_reg     <= skip_left_next;
            odd_nibble_reg    <= odd_nibble_next;
            high_nibble_reg   <= high_nibble_next;
            field_nibbles_reg <= field_nibbles_next;
            count_reg         <= count_next;
            address_reg       <= address_next;
            running_sum_reg   <= running_sum_next;
            data_left_reg     <= data_left_next;
            data_index_reg    <= data_index_next;
        end
    end

    srp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && has_result),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind              = out_data.kind;
    assign data_byte         = out_data.data_byte;
    assign byte_index        = out_data.byte_index;
    assign load_address      = out_data.load_address;
    assign byte_count        = out_data.byte_count;
    assign received_checksum = out_data.received_checksum;

endmodule

/* src/srp_out_buf.sv */
// ---------------------------------------------------------------------------
// S1 record parser result buffer
// Two-entry result queue between the parser state and the output channel.
// ---------------------------------------------------------------------------
`include "srecord_s1_parser_top_defines.svh"

module srp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srp_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output srp_pkg::result_t out_data
);
    import srp_pkg::*;

    result_t    ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop       = out_valid && !out_stall;
    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SRP_ASSERT_ALWAYS(a_fill_bound, count_reg != 2'd3, "result queue fill out of range")
    `SRP_ASSERT_ALWAYS(a_no_push_full, !(push && full), "result request pushed while full")
    `SRP_ASSERT_NEXT(a_fill_inc, push && !pop, count_reg == $past(count_reg) + 2'd1, "fill did not grow")
    `SRP_ASSERT_NEXT(a_fill_dec, pop && !push, count_reg == $past(count_reg) - 2'd1, "fill did not shrink")

endmodule

/* dv/tb_top.sv */
// ---------------------------------------------------------------------------
// S1 record parser testbench
// Feeds S1-style record text one character per request: a short directed
// table, then random records (mostly well-formed, some short, some with a
// bad hex digit, some cut off by a new start), under four idle/stall mixes.
// Directed results are checked against the table, random ones against an in-bench parser model.
// ---------------------------------------------------------------------------
module tb_top;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_CHARS = 425;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_CSUM
    } phase_t;

    typedef struct {
        logic [7:0] c;
        bit         s;
        bit         fixed;
        bit         has;
        result_t    r;
    } row_t;

    localparam result_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        record_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] load_address;
    logic [7:0]  byte_count;
    logic [7:0]  received_checksum;

    srecord_s1_parser_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .char_code         (char_code),
        .record_start      (record_start),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .load_address      (load_address),
        .byte_count        (byte_count),
        .received_checksum (received_checksum)
    );

    always #10 clk = ~clk;

    // parser model state
    phase_t      st_phase = PH_IDLE;
    logic [1:0]  st_skip = '0;
    logic        st_odd = 1'b0;
    logic [3:0]  st_hi = '0;
    logic [1:0]  st_fn = '0;
    logic [7:0]  st_count = '0;
    logic [15:0] st_addr = '0;
    logic [7:0]  st_sum = '0;
    logic [7:0]  st_left = '0;
    logic [7:0]  st_index = '0;

    result_t     pending_results[$];
    row_t        dir_rows[24];
    bit          row_fixed = 1'b0;
    bit          row_has = 1'b0;
    result_t     row_exp = '0;
    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          fails = 0;
    int          cycles = 0;
    int          requests = 0;
    int          results = 0;
    int          sent_chars = 0;
    int          records = 0;
    int          broken = 0;
    int          kind_seen[5] = '{default: 0};

    function automatic result_t mk_res(input kind_t k, input logic [7:0] db,
                                       input logic [7:0] idx, input logic [15:0] addr,
                                       input logic [7:0] cnt, input logic [7:0] cks);
        result_t r;
        r.kind = k;
        r.data_byte = db;
        r.byte_index = idx;
        r.load_address = addr;
        r.byte_count = cnt;
        r.received_checksum = cks;
        return r;
    endfunction

    function automatic row_t dir_row(input logic [7:0] c, input bit s, input bit fixed,
                                     input bit has, input result_t r);
        row_t row;
        row.c = c;
        row.s = s;
        row.fixed = fixed;
        row.has = has;
        row.r = r;
        return row;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] char_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'hFF;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
        end
        return (d == 8'hFF) ? 5'h10 : {1'b0, d[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return "0" + n;
        end
        return (lower ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input bit s, output result_t r);
        logic [4:0] nib;
        logic [7:0] b;
        logic [7:0] want;
        r = NO_RES;
        if (s)
        begin
            st_phase = PH_SKIP;
            st_skip = 2'd1;
            st_odd = 1'b0;
            st_hi = '0;
            st_fn = '0;
            st_count = '0;
            st_addr = '0;
            st_sum = '0;
            st_left = '0;
            st_index = '0;
            return 1'b0;
        end
        if (st_phase == PH_SKIP)
        begin
            if (st_skip != 0)
            begin
                st_skip = st_skip - 1'b1;
            end
            if (st_skip == 0)
            begin
                st_phase = PH_COUNT;
            end
            return 1'b0;
        end
        if (st_phase == PH_IDLE)
        begin
            return 1'b0;
        end
        nib = char_nibble(c);
        if (nib[4])
        begin
            st_phase = PH_IDLE;
            r = mk_res(KIND_BADHEX, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
            return 1'b1;
        end
        if (st_phase == PH_ADDR)
        begin
            st_addr = {st_addr[11:0], nib[3:0]};
            if (st_fn < 2'd3)
            begin
                st_fn = st_fn + 1'b1;
                return 1'b0;
            end
            st_fn = '0;
            st_sum = st_sum + st_addr[15:8] + st_addr[7:0];
            st_phase = (st_left != 0) ? PH_DATA : PH_CSUM;
            return 1'b0;
        end
        if (!st_odd)
        begin
            st_hi = nib[3:0];
            st_odd = 1'b1;
            return 1'b0;
        end
        st_odd = 1'b0;
        b = {st_hi, nib[3:0]};
        case (st_phase)
            PH_COUNT:
            begin
                st_count = b;
                if (b < COUNT_MIN)
                begin
                    st_phase = PH_IDLE;
                    r = mk_res(KIND_SHORT, 8'd0, 8'd0, 16'd0, b, 8'd0);
                    return 1'b1;
                end
                st_sum = b;
                st_left = b - COUNT_MIN;
                st_index = '0;
                st_addr = '0;
                st_fn = '0;
                st_phase = PH_ADDR;
                return 1'b0;
            end
            PH_DATA:
            begin
                r = mk_res(KIND_DATA, b, st_index, st_addr, st_count, 8'd0);
                st_sum = st_sum + b;
                st_index = st_index + 1'b1;
                st_left = st_left - 1'b1;
                if (st_left == 0)
                begin
                    st_phase = PH_CSUM;
                end
                return 1'b1;
            end
            default:
            begin
                want = 8'hFF - st_sum;
                st_phase = PH_IDLE;
                r = mk_res((b == want) ? KIND_OK : KIND_MISMATCH, 8'd0, 8'd0,
                           st_addr, st_count, b);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // handshakes sampled mid-cycle, acted on at the next rising edge
    always @(negedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        bit      produced;
        in_fire = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (out_fire)
        begin
            got = mk_res(kind_t'(kind), data_byte, byte_index, load_address,
                         byte_count, received_checksum);
            results++;
            if (kind < 3'd5)
            begin
                kind_seen[kind]++;
            end
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d", kind);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(got.kind));
                check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
                check_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
                check_field("load_address", want.load_address, got.load_address);
                check_field("byte_count", 16'(want.byte_count), 16'(got.byte_count));
                check_field("received_checksum", 16'(want.received_checksum),
                            16'(got.received_checksum));
            end
        end
        if (in_fire)
        begin
            requests++;
            produced = parse_char(char_code, record_start, pred);
            if (row_fixed)
            begin
                if (row_has)
                begin
                    pending_results.push_back(row_exp);
                end
            end
            else if (produced)
            begin
                pending_results.push_back(pred);
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results pending", cycles,
                   pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input bit s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        record_start <= s;
        @(posedge clk);
        while (!in_fire)
        begin
            @(posedge clk);
        end
        sent_chars++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic send_record();
        logic [7:0] bytes[$];
        logic [7:0] text[$];
        logic [7:0] sum;
        logic [7:0] bad;
        int         mode;
        int         cnt;
        int         pos;
        mode = $urandom_range(99);
        records++;
        text.push_back(8'($urandom_range(255)));
        text.push_back(8'($urandom_range(255)));
        if (mode < 8)
        begin
            cnt = $urandom_range(2);
        end
        else if ($urandom_range(99) < 3)
        begin
            cnt = $urandom_range(255, 3);
        end
        else
        begin
            cnt = $urandom_range(10, 3);
        end
        bytes.push_back(8'(cnt));
        if (cnt >= 3)
        begin
            repeat (cnt - 1)
            begin
                bytes.push_back(8'($urandom_range(255)));
            end
            sum = '0;
            foreach (bytes[i])
            begin
                sum = sum + bytes[i];
            end
            bytes.push_back(($urandom_range(99) < 80) ? 8'hFF - sum
                                                       : 8'($urandom_range(255)));
        end
        foreach (bytes[i])
        begin
            text.push_back(hex_char(bytes[i][7:4], 1'($urandom_range(1))));
            text.push_back(hex_char(bytes[i][3:0], 1'($urandom_range(1))));
        end
        if (mode >= 80 && mode < 90)
        begin
            broken++;
            do
            begin
                bad = 8'($urandom_range(255));
            end
            while (char_nibble(bad) < 5'h10);
            pos = $urandom_range(text.size() - 1, 2);
            text[pos] = bad;
        end
        else if (mode >= 90)
        begin
            broken++;
            pos = $urandom_range(text.size() - 1, 1);
            while (text.size() > pos)
            begin
                void'(text.pop_back());
            end
        end
        foreach (text[i])
        begin
            send_char(text[i], i == 0);
        end
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(3, 1))
            begin
                send_char(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        int phase_start;
        idle_mix = '{0, 47, 0, 7};
        stall_mix = '{0, 0, 47, 7};

        dir_rows[0]  = dir_row("Q", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[1]  = dir_row("S", 1'b1, 1'b1, 1'b0, NO_RES);
        dir_rows[2]  = dir_row("1", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[3]  = dir_row("0", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[4]  = dir_row("4", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[5]  = dir_row("F", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[6]  = dir_row("F", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[7]  = dir_row("F", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[8]  = dir_row("F", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[9]  = dir_row("f", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[10] = dir_row("f", 1'b0, 1'b0, 1'b0, NO_RES);
        dir_rows[11] = dir_row("F", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[12] = dir_row("E", 1'b0, 1'b1, 1'b1,
                               mk_res(KIND_OK, 8'h00, 8'h00, 16'hFFFF, 8'h04, 8'hFE));
        dir_rows[13] = dir_row("S", 1'b1, 1'b1, 1'b0, NO_RES);
        dir_rows[14] = dir_row("1", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[15] = dir_row("1", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[16] = dir_row("S", 1'b1, 1'b1, 1'b0, NO_RES);
        dir_rows[17] = dir_row("9", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[18] = dir_row("0", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[19] = dir_row("2", 1'b0, 1'b1, 1'b1,
                               mk_res(KIND_SHORT, 8'h00, 8'h00, 16'h0000, 8'h02, 8'h00));
        dir_rows[20] = dir_row("S", 1'b1, 1'b1, 1'b0, NO_RES);
        dir_rows[21] = dir_row("1", 1'b0, 1'b1, 1'b0, NO_RES);
        dir_rows[22] = dir_row("g", 1'b0, 1'b1, 1'b1,
                               mk_res(KIND_BADHEX, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
        dir_rows[23] = dir_row("0", 1'b0, 1'b1, 1'b0, NO_RES);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row_fixed = dir_rows[i].fixed;
            row_has = dir_rows[i].has;
            row_exp = dir_rows[i].r;
            send_char(dir_rows[i].c, dir_rows[i].s);
        end
        row_fixed = 1'b0;
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            phase_start = sent_chars;
            while (sent_chars - phase_start < PHASE_CHARS)
            begin
                send_record();
            end
            // sender holds off until the parser has nothing outstanding
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests, got %0d results over %0d random records (%0d broken)",
                 requests, results, records, broken);
        $display("Results: data %0d, ok %0d, mismatch %0d, bad hex %0d, short count %0d",
                 kind_seen[KIND_DATA], kind_seen[KIND_OK], kind_seen[KIND_MISMATCH],
                 kind_seen[KIND_BADHEX], kind_seen[KIND_SHORT]);
        if (fails == 0 && pending_results.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            if (pending_results.size() != 0)
            begin
                $error("%0d expected results never arrived", pending_results.size());
            end
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
